// ===== src/mlpf_pkg.sv =====
// Shared constants and types for the matrix local peak finder.
// No dependencies; every other file refers to this package by scoped names.
package mlpf_pkg;

   // default sizes, handed to the top level as parameter defaults
   localparam int MAX_COLS_DEF     = 1024;
   localparam int MAX_ROWS_DEF     = 1024;
   localparam int SAMPLE_WIDTH_DEF = 32;

   // fixed field widths
   localparam int POS_W      = 11;
   localparam int COUNT_W    = 20;
   localparam int BORDER_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER_VALUE = 2'd2;

   // input command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   // line buffer access control
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } lb_cmd_type;

endpackage

// ===== src/mlpf_if.sv =====
// Channel interfaces of the matrix local peak finder: sample input, result
// output and register write. Depends on mlpf_pkg.
interface mlpf_req_if #(
   parameter int SAMPLE_WIDTH = mlpf_pkg::SAMPLE_WIDTH_DEF
) ();
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, command, sample, input ready);
   modport sink (input valid, command, sample, output ready);
endinterface

interface mlpf_rsp_if ();
   logic                         valid;
   logic                         ready;
   logic                         peak_valid;
   logic [mlpf_pkg::POS_W-1:0]   site_row;
   logic [mlpf_pkg::POS_W-1:0]   site_col;
   logic [mlpf_pkg::COUNT_W-1:0] peak_count;
   logic                         frame_end;
   logic                         order_error;

   modport source (output valid, peak_valid, site_row, site_col, peak_count, frame_end,
                   order_error, input ready);
   modport sink (input valid, peak_valid, site_row, site_col, peak_count, frame_end,
                 order_error, output ready);
endinterface

interface mlpf_csr_if ();
   logic                            valid;
   logic                            ready;
   logic [mlpf_pkg::CSR_IDX_W-1:0]  index;
   logic [mlpf_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/mlpf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on mlpf_pkg for parameter defaults.
module mlpf_ram #(
   parameter int WIDTH = mlpf_pkg::SAMPLE_WIDTH_DEF,
   parameter int DEPTH = mlpf_pkg::MAX_COLS_DEF
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mlpf_line_buf.sv =====
// Two row stores (upper and center rows) with forwarding of writes that hit
// the entry last read. Depends on mlpf_pkg and mlpf_ram.
module mlpf_line_buf #(
   parameter int MAX_COLS     = mlpf_pkg::MAX_COLS_DEF,
   parameter int SAMPLE_WIDTH = mlpf_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  mlpf_pkg::lb_cmd_type                          cmd,
   input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] rd_addr,
   input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] wr_addr,
   input  logic [SAMPLE_WIDTH-1:0]                       wr_center,
   input  logic [SAMPLE_WIDTH-1:0]                       wr_upper,
   output logic [SAMPLE_WIDTH-1:0]                       rd_center,
   output logic [SAMPLE_WIDTH-1:0]                       rd_upper
);

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic [SAMPLE_WIDTH-1:0] ram_center;
   logic [SAMPLE_WIDTH-1:0] ram_upper;

   // entry last read, and any write to it that landed after the read
   logic [COL_W-1:0]        rd_addr_ff, rd_addr_in;
   logic                    ovr_valid_ff, ovr_valid_in;
   logic [SAMPLE_WIDTH-1:0] ovr_center_ff, ovr_center_in;
   logic [SAMPLE_WIDTH-1:0] ovr_upper_ff, ovr_upper_in;

   logic                    hit_held;
   logic [SAMPLE_WIDTH-1:0] held_center;
   logic [SAMPLE_WIDTH-1:0] held_upper;

   mlpf_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_COLS)
   ) u_center_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_center),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_center)
   );

   mlpf_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_COLS)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_upper),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_upper)
   );

   assign hit_held    = cmd.wr_en && (wr_addr == rd_addr_ff);
   assign held_center = ovr_valid_ff ? ovr_center_ff : ram_center;
   assign held_upper  = ovr_valid_ff ? ovr_upper_ff : ram_upper;

   // view of the last-read entry including a write in this very cycle
   assign rd_center = hit_held ? wr_center : held_center;
   assign rd_upper  = hit_held ? wr_upper : held_upper;

   always_comb begin
      rd_addr_in    = rd_addr_ff;
      ovr_valid_in  = ovr_valid_ff;
      ovr_center_in = ovr_center_ff;
      ovr_upper_in  = ovr_upper_ff;
      if (cmd.rd_en) begin
         rd_addr_in    = rd_addr;
         ovr_valid_in  = cmd.wr_en && (wr_addr == rd_addr);
         ovr_center_in = wr_center;
         ovr_upper_in  = wr_upper;
      end else if (hit_held) begin
         ovr_valid_in  = 1'b1;
         ovr_center_in = wr_center;
         ovr_upper_in  = wr_upper;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_addr_ff   <= '0;
         ovr_valid_ff <= 1'b0;
      end else begin
         rd_addr_ff   <= rd_addr_in;
         ovr_valid_ff <= ovr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ovr_center_ff <= ovr_center_in;
      ovr_upper_ff  <= ovr_upper_in;
   end

endmodule

// ===== src/matrix_local_peak_finder.sv =====
// Matrix local peak finder: takes one sample per clock in raster order, save
// when results back up, and reports, per decided position, whether it beats
// its four neighbours. Depends on mlpf_pkg, mlpf interfaces and mlpf_line_buf.
//
// Throughput is one item per clock while the output is taken; a result is
// worked out in the compare stage (during which the right neighbour is read
// from the center row store) and then held in the output register, which
// lets the next item in while a result waits. The rate is set by the single
// read-modify-write per item on the two row RAMs: each in-phase item reads
// the entry for the next column, each sample writes back its own column, with
// forwarding when the two meet on narrow frames. Samples of the first row give
// no result; after the last sample, col_count drain items decide the last row,
// and the final one carries frame_end. A command that does not fit the current
// phase gives one result with order_error set and changes nothing. Row stores
// come up uninitialized; no clearing pass is run after reset. Sizes and the
// border value should be written only between frames.
module matrix_local_peak_finder #(
   parameter int MAX_COLS     = mlpf_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS     = mlpf_pkg::MAX_ROWS_DEF,
   parameter int SAMPLE_WIDTH = mlpf_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mlpf_req_if.sink    req_bus,
   mlpf_rsp_if.source  rsp_bus,
   mlpf_csr_if.sink    csr_bus
);

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CSZ_W = $clog2(MAX_COLS + 1);
   localparam int RSZ_W = $clog2(MAX_ROWS + 1);
   localparam int CW    = (SAMPLE_WIDTH > mlpf_pkg::BORDER_W) ?
                          SAMPLE_WIDTH : mlpf_pkg::BORDER_W;
   localparam int POS_W   = mlpf_pkg::POS_W;
   localparam int COUNT_W = mlpf_pkg::COUNT_W;

   // configuration
   logic [POS_W-1:0]                          csr_row_ff, csr_row_in;
   logic [POS_W-1:0]                          csr_col_ff, csr_col_in;
   logic signed [mlpf_pkg::BORDER_W-1:0]      border_ff, border_in;
   logic [CSZ_W-1:0]                          col_size;
   logic [RSZ_W-1:0]                          row_size;

   // scan position
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_nxt;
   logic             draining_ff, draining_in;
   logic             last_col;
   logic             last_row;
   logic             accept;
   logic             cmd_err;

   // compare stage
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_err_ff;
   logic                           s1_decide_ff;
   logic                           s1_drain_ff;
   logic                           s1_frame_end_ff;
   logic                           s1_top_ff;
   logic                           s1_left_edge_ff;
   logic                           s1_right_edge_ff;
   logic [ROW_W-1:0]               s1_row_ff;
   logic [COL_W-1:0]               s1_col_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_mid_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_up_ff;
   logic                           s1_need_out;
   logic                           s1_fire;

   logic signed [SAMPLE_WIDTH-1:0] left_ff;
   logic [COUNT_W-1:0]             peak_total_ff, peak_total_in;
   logic [COUNT_W-1:0]             count_next;

   logic signed [SAMPLE_WIDTH-1:0] lb_center;
   logic signed [SAMPLE_WIDTH-1:0] lb_upper;
   mlpf_pkg::lb_cmd_type           lb_cmd;

   logic signed [CW-1:0] border_v, mid_v, up_v, down_v, left_v, right_v;
   logic                 is_peak;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_peak_ff;
   logic [POS_W-1:0]   rsp_row_ff;
   logic [POS_W-1:0]   rsp_col_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_frame_end_ff;
   logic               rsp_err_ff;

   // ---------------- configuration port ----------------
   assign csr_bus.ready = 1'b1;

   always_comb begin
      csr_row_in = csr_row_ff;
      csr_col_in = csr_col_ff;
      border_in  = border_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            mlpf_pkg::CSR_ROW_COUNT:    csr_row_in = csr_bus.data[POS_W-1:0];
            mlpf_pkg::CSR_COL_COUNT:    csr_col_in = csr_bus.data[POS_W-1:0];
            mlpf_pkg::CSR_BORDER_VALUE: border_in  = csr_bus.data[mlpf_pkg::BORDER_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize clamps to MAX_COLS or MAX_ROWS
   always_comb begin
      if (csr_col_ff == '0) begin
         col_size = CSZ_W'(1);
      end else if (32'(csr_col_ff) > 32'(MAX_COLS)) begin
         col_size = CSZ_W'(MAX_COLS);
      end else begin
         col_size = CSZ_W'(csr_col_ff);
      end
      if (csr_row_ff == '0) begin
         row_size = RSZ_W'(1);
      end else if (32'(csr_row_ff) > 32'(MAX_ROWS)) begin
         row_size = RSZ_W'(MAX_ROWS);
      end else begin
         row_size = RSZ_W'(csr_row_ff);
      end
   end

   // ---------------- accept stage ----------------
   assign accept   = req_bus.valid && req_bus.ready;
   assign cmd_err  = (req_bus.command == mlpf_pkg::CMD_DRAIN) != draining_ff;
   assign last_col = (32'(col_ff) + 32'd1) >= 32'(col_size);
   assign last_row = (32'(row_ff) + 32'd1) >= 32'(row_size);
   assign col_nxt  = last_col ? '0 : COL_W'(32'(col_ff) + 32'd1);

   assign req_bus.ready = !s1_valid_ff || s1_fire;

   always_comb begin
      row_in      = row_ff;
      draining_in = draining_ff;
      if (accept && !cmd_err && last_col) begin
         if (draining_ff) begin
            row_in      = '0;
            draining_in = 1'b0;
         end else if (last_row) begin
            draining_in = 1'b1;
         end else begin
            row_in = ROW_W'(32'(row_ff) + 32'd1);
         end
      end
   end

   // prefetch the entry of the next column; write back the column in compare
   assign lb_cmd.rd_en = accept && !cmd_err;
   assign lb_cmd.wr_en = s1_fire && !s1_err_ff && !s1_drain_ff;

   mlpf_line_buf #(
      .MAX_COLS     (MAX_COLS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .cmd       (lb_cmd),
      .rd_addr   (col_nxt),
      .wr_addr   (s1_col_ff),
      .wr_center (s1_sample_ff),
      .wr_upper  (s1_mid_ff),
      .rd_center (lb_center),
      .rd_upper  (lb_upper)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------- compare stage ----------------
   assign s1_need_out = s1_err_ff || s1_decide_ff;
   assign s1_fire     = s1_valid_ff && (!s1_need_out || !rsp_valid_ff || rsp_bus.ready);

   assign border_v = CW'(border_ff);
   assign mid_v    = CW'(s1_mid_ff);
   assign up_v     = s1_top_ff ? border_v : CW'(s1_up_ff);
   assign down_v   = s1_drain_ff ? border_v : CW'(s1_sample_ff);
   assign left_v   = s1_left_edge_ff ? border_v : CW'(left_ff);
   assign right_v  = s1_right_edge_ff ? border_v : CW'(lb_center);
   assign is_peak  = (mid_v > up_v) && (mid_v > down_v) && (mid_v > left_v) &&
                     (mid_v > right_v);

   assign count_next = (is_peak && (peak_total_ff != '1)) ?
                       peak_total_ff + COUNT_W'(1) : peak_total_ff;

   always_comb begin
      peak_total_in = peak_total_ff;
      if (s1_fire && s1_decide_ff && !s1_err_ff) begin
         peak_total_in = s1_frame_end_ff ? '0 : count_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_need_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_row_ff    <= POS_W'(1);
         csr_col_ff    <= POS_W'(1);
         border_ff     <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         draining_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         peak_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         csr_row_ff    <= csr_row_in;
         csr_col_ff    <= csr_col_in;
         border_ff     <= border_in;
         row_ff        <= row_in;
         if (accept && !cmd_err) begin
            col_ff <= col_nxt;
         end
         draining_ff   <= draining_in;
         s1_valid_ff   <= s1_valid_in;
         peak_total_ff <= peak_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_err_ff        <= cmd_err;
         s1_decide_ff     <= draining_ff || (row_ff != '0);
         s1_drain_ff      <= draining_ff;
         s1_frame_end_ff  <= draining_ff && last_col;
         s1_top_ff        <= draining_ff ? (row_ff == '0) : (row_ff == ROW_W'(1));
         s1_left_edge_ff  <= (col_ff == '0);
         s1_right_edge_ff <= last_col;
         s1_row_ff        <= draining_ff ? row_ff : row_ff - ROW_W'(1);
         s1_col_ff        <= col_ff;
         s1_sample_ff     <= req_bus.sample;
         s1_mid_ff        <= lb_center;
         s1_up_ff         <= lb_upper;
      end
      if (s1_fire && s1_decide_ff && !s1_err_ff) begin
         left_ff <= s1_mid_ff;
      end
      if (s1_fire && s1_need_out) begin
         if (s1_err_ff) begin
            rsp_peak_ff      <= 1'b0;
            rsp_row_ff       <= '0;
            rsp_col_ff       <= '0;
            rsp_count_ff     <= '0;
            rsp_frame_end_ff <= 1'b0;
            rsp_err_ff       <= 1'b1;
         end else begin
            rsp_peak_ff      <= is_peak;
            rsp_row_ff       <= POS_W'(32'(s1_row_ff) + 32'd1);
            rsp_col_ff       <= POS_W'(32'(s1_col_ff) + 32'd1);
            rsp_count_ff     <= count_next;
            rsp_frame_end_ff <= s1_frame_end_ff;
            rsp_err_ff       <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.peak_valid  = rsp_peak_ff;
   assign rsp_bus.site_row    = rsp_row_ff;
   assign rsp_bus.site_col    = rsp_col_ff;
   assign rsp_bus.peak_count  = rsp_count_ff;
   assign rsp_bus.frame_end   = rsp_frame_end_ff;
   assign rsp_bus.order_error = rsp_err_ff;

`ifndef SYNTHESIS
   // the prefetched store entry always belongs to the column now expected
   a_prefetch_col: assert property (@(posedge clock) disable iff (reset)
      (accept && !cmd_err) |=> (col_ff == $past(col_nxt)))
      else $error("row store prefetch address out of step with column");

   // the final drain clears the running peak count
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_decide_ff && !s1_err_ff && s1_frame_end_ff) |=> (peak_total_ff == '0))
      else $error("peak count not cleared at frame end");

   // inside a frame the peak count never goes down
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_decide_ff && !s1_err_ff && !s1_frame_end_ff) |=>
      (peak_total_ff >= $past(peak_total_ff)))
      else $error("peak count decreased inside a frame");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for matrix_local_peak_finder: directed and random raster frames, each result
// checked against a line-buffer predictor kept inside the bench.
// Depends on mlpf_pkg, the mlpf interfaces and the matrix_local_peak_finder top level.
module tb;

   localparam int N_COLS  = mlpf_pkg::MAX_COLS_DEF;
   localparam int N_ROWS  = mlpf_pkg::MAX_ROWS_DEF;
   localparam int S_W     = mlpf_pkg::SAMPLE_WIDTH_DEF;
   localparam int POS_W   = mlpf_pkg::POS_W;
   localparam int COUNT_W = mlpf_pkg::COUNT_W;
   localparam logic [COUNT_W-1:0] TALLY_MAX = '1;

   typedef logic signed [S_W-1:0] sample_type;

   typedef struct packed {
      logic               peak_valid;
      logic [POS_W-1:0]   site_row;
      logic [POS_W-1:0]   site_col;
      logic [COUNT_W-1:0] peak_count;
      logic               frame_end;
      logic               order_error;
   } decision_type;

   typedef enum {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   mlpf_req_if req_bus ();
   mlpf_rsp_if rsp_bus ();
   mlpf_csr_if csr_bus ();

   matrix_local_peak_finder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state
   logic [POS_W-1:0]   rows_reg;
   logic [POS_W-1:0]   cols_reg;
   sample_type         border_reg;
   sample_type         upper_line [N_COLS];
   sample_type         middle_line [N_COLS];
   sample_type         left_val;
   int unsigned        row_pos;
   int unsigned        col_pos;
   logic               draining;
   logic [COUNT_W-1:0] tally;

   decision_type decisions_due [$];

   int fail_count        = 0;
   int results_seen      = 0;
   int frames_seen       = 0;
   int peaks_seen        = 0;
   int phase_errors_seen = 0;
   int burst_left        = 0;
   bit sender_steady     = 1'b0;

   rx_mode_type rx_mode   = RX_OPEN;
   int          mode_left = 0;
   int          stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(logic [POS_W-1:0] v, int unsigned limit);
      if (v == 0)
         return 1;
      if (v > limit)
         return limit;
      return 32'(v);
   endfunction

   // decides position (d, c); below is the value under it
   function automatic decision_type judge_position(int unsigned d, int unsigned c,
         int unsigned cols, sample_type below, logic last);
      sample_type   mid;
      sample_type   above;
      sample_type   west;
      sample_type   east;
      decision_type r;
      mid   = middle_line[c];
      above = (d == 0) ? border_reg : upper_line[c];
      west  = (c == 0) ? border_reg : left_val;
      east  = (c + 1 >= cols) ? border_reg : middle_line[c + 1];
      r = '0;
      r.peak_valid = (mid > above) && (mid > below) && (mid > west) && (mid > east);
      if (r.peak_valid && tally != TALLY_MAX)
         tally++;
      left_val     = mid;
      r.site_row   = POS_W'(d + 1);
      r.site_col   = POS_W'(c + 1);
      r.peak_count = tally;
      r.frame_end  = last;
      return r;
   endfunction

   function automatic void track_item(logic cmd, sample_type smp);
      int unsigned  rows;
      int unsigned  cols;
      int unsigned  c;
      logic         last_col;
      decision_type r;
      rows = clamp_dim(rows_reg, N_ROWS);
      cols = clamp_dim(cols_reg, N_COLS);
      c = col_pos;
      last_col = (c + 1 >= cols);
      if ((cmd == mlpf_pkg::CMD_DRAIN) != draining) begin
         r = '0;
         r.order_error = 1'b1;
         decisions_due.insert(decisions_due.size(), r);
         return;
      end
      if (c >= N_COLS)
         c = N_COLS - 1;
      if (draining) begin
         r = judge_position(row_pos, c, cols, border_reg, last_col);
         decisions_due.insert(decisions_due.size(), r);
         if (last_col) begin
            row_pos  = 0;
            col_pos  = 0;
            draining = 1'b0;
            tally    = '0;
         end else begin
            col_pos = c + 1;
         end
         return;
      end
      if (row_pos > 0) begin
         r = judge_position(row_pos - 1, c, cols, smp, 1'b0);
         decisions_due.insert(decisions_due.size(), r);
         upper_line[c] = middle_line[c];
      end
      middle_line[c] = smp;
      if (last_col) begin
         col_pos = 0;
         if (row_pos + 1 >= rows)
            draining = 1'b1;
         else
            row_pos++;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic sample_type pick_sample(int spread);
      case ($urandom_range(0, 15))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         default: begin
            if (spread == 0)
               return $urandom;
            return $signed($urandom_range(0, 2 * spread)) - spread;
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_item(logic cmd, sample_type smp);
      int gap;
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.sample  <= smp;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      track_item(cmd, smp);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = sender_steady ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // stop sending and wait for every outstanding result, plus pipeline slack
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (decisions_due.size() != 0)
         @(posedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_csr(logic [mlpf_pkg::CSR_IDX_W-1:0] idx,
         logic [mlpf_pkg::CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         mlpf_pkg::CSR_ROW_COUNT:    rows_reg   = value[POS_W-1:0];
         mlpf_pkg::CSR_COL_COUNT:    cols_reg   = value[POS_W-1:0];
         mlpf_pkg::CSR_BORDER_VALUE: border_reg = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_frame(int unsigned rows, int unsigned cols, sample_type border);
      write_csr(mlpf_pkg::CSR_ROW_COUNT, rows);
      write_csr(mlpf_pkg::CSR_COL_COUNT, cols);
      write_csr(mlpf_pkg::CSR_BORDER_VALUE, border);
      csr_bus.valid <= 1'b0;
   endtask

   // one full frame; noise_pct adds wrong-phase transactions, hold_mid waits
   // for all results before the last sample
   task automatic send_frame(int unsigned rows, int unsigned cols, int spread, int noise_pct,
         bit hold_mid);
      for (int unsigned r = 0; r < rows; r++) begin
         for (int unsigned c = 0; c < cols; c++) begin
            if ($urandom_range(0, 99) < noise_pct)
               send_item(mlpf_pkg::CMD_DRAIN, $urandom);
            if (hold_mid && r == rows - 1 && c == cols - 1)
               settle();
            send_item(mlpf_pkg::CMD_SAMPLE, pick_sample(spread));
         end
      end
      for (int unsigned c = 0; c < cols; c++) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_item(mlpf_pkg::CMD_SAMPLE, $urandom);
         send_item(mlpf_pkg::CMD_DRAIN, $urandom);
      end
   endtask

   task automatic test_directed_frame();
      sample_type grid [9] = '{32'sh80000000, 7, -1,
                               7, 32'sh7fffffff, 7,
                               3, 6, 3};
      set_frame(3, 3, 0);
      send_item(mlpf_pkg::CMD_DRAIN, 0);                // drain before any sample
      foreach (grid[i])
         send_item(mlpf_pkg::CMD_SAMPLE, grid[i]);
      send_item(mlpf_pkg::CMD_DRAIN, 32'h5a5a5a5a);
      send_item(mlpf_pkg::CMD_SAMPLE, 32'sh7fffffff);   // sample inside the drain phase
      send_item(mlpf_pkg::CMD_DRAIN, 0);
      send_item(mlpf_pkg::CMD_DRAIN, -1);
      settle();
   endtask

   task automatic test_border_extremes();
      set_frame(1, 1, 32'sh80000000);
      send_item(mlpf_pkg::CMD_SAMPLE, 32'sh80000000);   // ties the border, no peak
      send_item(mlpf_pkg::CMD_DRAIN, 0);
      send_item(mlpf_pkg::CMD_SAMPLE, 32'sh80000001);
      send_item(mlpf_pkg::CMD_DRAIN, 0);
      settle();
      set_frame(2, 1, 32'sh7fffffff);
      send_item(mlpf_pkg::CMD_SAMPLE, 32'sh7fffffff);
      send_item(mlpf_pkg::CMD_SAMPLE, 32'sh7ffffffe);
      send_item(mlpf_pkg::CMD_DRAIN, 0);
      settle();
   endtask

   task automatic test_random_frames();
      int unsigned counted = 0;
      int unsigned rows = 1;
      int unsigned cols = 1;
      sample_type  border;
      int          spread;
      bit          held = 1'b0;
      while (counted < 780) begin
         if (counted == 0 || $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0: begin
                  rows = $urandom_range(1, 40);
                  cols = $urandom_range(1, 3);
               end
               1: begin
                  rows = $urandom_range(1, 3);
                  cols = $urandom_range(20, 64);
               end
               default: begin
                  rows = $urandom_range(1, 6);
                  cols = $urandom_range(1, 10);
               end
            endcase
            case ($urandom_range(0, 5))
               0: border = 0;
               1: border = 32'sh80000000;
               2: border = 32'sh7fffffff;
               3: border = $urandom;
               default: border = $signed($urandom_range(0, 6)) - 3;
            endcase
            settle();
            set_frame(rows, cols, border);
         end
         case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 1;
            2: spread = 3;
            default: spread = 20;
         endcase
         sender_steady = ($urandom_range(0, 3) == 0);
         send_frame(rows, cols, spread, 4, !held && rows > 1);
         if (rows > 1)
            held = 1'b1;
         counted += rows * cols + cols;
         if ($urandom_range(0, 3) == 0)
            settle();
      end
      settle();
      sender_steady = 1'b0;
   endtask

   task automatic test_size_extremes();
      set_frame(N_ROWS, 1, $urandom);
      send_frame(N_ROWS, 1, 2, 0, 1'b0);
      settle();
   endtask

   // receiver readiness: open, coin-flip, or bursts of stalls, switching now and then
   always @(negedge clock) begin
      if (mode_left == 0) begin
         rx_mode   = rx_mode_type'($urandom_range(0, 2));
         mode_left = $urandom_range(40, 400);
      end else begin
         mode_left--;
      end
      case (rx_mode)
         RX_OPEN: rsp_bus.ready <= 1'b1;
         RX_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
               if ($urandom_range(0, 5) == 0)
                  stall_left = $urandom_range(1, 12);
            end
         end
      endcase
   end

   always @(posedge clock) begin
      decision_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         if (decisions_due.size() == 0) begin
            $error("unexpected result transaction: row %0d col %0d error %0b",
                   rsp_bus.site_row, rsp_bus.site_col, rsp_bus.order_error);
            fail_count++;
         end else begin
            want = decisions_due.pop_front();
            check_field("peak_valid", 32'(want.peak_valid), 32'(rsp_bus.peak_valid));
            check_field("site_row", 32'(want.site_row), 32'(rsp_bus.site_row));
            check_field("site_col", 32'(want.site_col), 32'(rsp_bus.site_col));
            check_field("peak_count", 32'(want.peak_count), 32'(rsp_bus.peak_count));
            check_field("frame_end", 32'(want.frame_end), 32'(rsp_bus.frame_end));
            check_field("order_error", 32'(want.order_error), 32'(rsp_bus.order_error));
            if (want.frame_end)
               frames_seen++;
            if (want.peak_valid)
               peaks_seen++;
            if (want.order_error)
               phase_errors_seen++;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.command = mlpf_pkg::CMD_SAMPLE;
      req_bus.sample  = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = mlpf_pkg::CSR_ROW_COUNT;
      csr_bus.data    = '0;
      rsp_bus.ready   = 1'b0;
      rows_reg   = POS_W'(1);
      cols_reg   = POS_W'(1);
      border_reg = '0;
      left_val   = '0;
      row_pos    = 0;
      col_pos    = 0;
      draining   = 1'b0;
      tally      = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_frame();
      test_border_extremes();
      test_random_frames();
      test_size_extremes();
      settle();

      $display("Checked %0d results over %0d frames: %0d peaks, %0d phase errors.",
               results_seen, frames_seen, peaks_seen, phase_errors_seen);
      $display("Frames ranged from 1x1 up to %0dx1 and 3x64, borders at both extremes.",
               N_ROWS);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
